>>> rtl/core/b64gd_pkg.sv
// Package for the base64 group decoder: item types, status codes and
// the character-to-sextet lookup. No dependencies.
package b64gd_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 2;
	localparam int unsigned SEXTET_W        = 6;
	localparam int unsigned ACCUM_W         = 3 * SEXTET_W;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BADCHAR = 2'd1,
		ST_PARTIAL = 2'd2
	} status_t;

	typedef struct packed {
		logic [7:0] symbol;
		logic       is_final;
	} in_item_t;

	typedef struct packed {
		logic [7:0] byte_hi;
		logic [7:0] byte_mid;
		logic [7:0] byte_lo;
		status_t    status;
		logic       ends_buffer;
	} out_item_t;

	// A character after classification, as it waits in the queue.
	typedef struct packed {
		logic [SEXTET_W-1:0] sextet;
		logic                bad;
		logic                is_final;
	} cls_item_t;

	// Returns {bad, sextet}. The pad character maps to zero.
	function automatic logic [SEXTET_W:0] map_symbol(input logic [7:0] c);
		logic [7:0] d;
		logic [SEXTET_W:0] r;
		d = 8'd0;
		r = {1'b1, {SEXTET_W{1'b0}}};
		if (c inside {[8'h41:8'h5A]}) begin
			d = c - 8'h41;
			r = {1'b0, d[SEXTET_W-1:0]};
		end else if (c inside {[8'h61:8'h7A]}) begin
			d = c - 8'h61 + 8'd26;
			r = {1'b0, d[SEXTET_W-1:0]};
		end else if (c inside {[8'h30:8'h39]}) begin
			d = c - 8'h30 + 8'd52;
			r = {1'b0, d[SEXTET_W-1:0]};
		end else if (c == 8'h2B) begin
			r = {1'b0, 6'd62};
		end else if (c == 8'h2F) begin
			r = {1'b0, 6'd63};
		end else if (c == 8'h3D) begin
			r = {1'b0, 6'd0};
		end
		return r;
	endfunction

endpackage

>>> rtl/core/b64gd_front.sv
// Front end: accepts input characters and classifies them into sextets.
// Depends on b64gd_pkg.
module b64gd_front import b64gd_pkg::*; (
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	input  logic      q_full,
	output logic      q_push,
	output cls_item_t q_item
);

	logic [SEXTET_W:0] mapped;

	assign mapped          = map_symbol(in_item.symbol);
	assign in_ready        = !q_full;
	assign q_push          = in_valid && !q_full;
	assign q_item.sextet   = mapped[SEXTET_W-1:0];
	assign q_item.bad      = mapped[SEXTET_W];
	assign q_item.is_final = in_item.is_final;

endmodule

>>> rtl/core/b64gd_queue.sv
// Short queue of classified items between the front and back ends.
// Depends on b64gd_pkg.
module b64gd_queue import b64gd_pkg::*; #(
	parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  cls_item_t push_item,
	output logic      full,
	input  logic      pop,
	output logic      empty,
	output cls_item_t head
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	cls_item_t          entries_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/core/b64gd_back.sv
// Back end: packs sextets into groups, tracks errors and buffer ends, and
// holds the result in an output register. Depends on b64gd_pkg.
module b64gd_back import b64gd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_empty,
	input  cls_item_t q_head,
	output logic      q_pop,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	logic [1:0]         fill_q;
	logic [ACCUM_W-1:0] accum_q;
	logic               err_q;
	logic               out_valid_q;
	out_item_t          out_q;

	logic [1:0]         fill_d;
	logic [ACCUM_W-1:0] accum_d;
	logic               err_d;
	logic               emit;
	out_item_t          res;

	assign q_pop     = !q_empty && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	always_comb begin
		fill_d          = fill_q;
		accum_d         = accum_q;
		err_d           = err_q;
		emit            = 1'b0;
		res.byte_hi     = '0;
		res.byte_mid    = '0;
		res.byte_lo     = '0;
		res.status      = ST_OK;
		res.ends_buffer = q_head.is_final;
		if (err_q) begin
			// Characters after an error are dropped until the buffer ends.
			if (q_head.is_final) begin
				err_d = 1'b0;
			end
		end else if (q_head.bad) begin
			emit       = 1'b1;
			res.status = ST_BADCHAR;
			fill_d     = '0;
			accum_d    = '0;
			err_d      = !q_head.is_final;
		end else if (fill_q == 2'd3) begin
			emit = 1'b1;
			{res.byte_hi, res.byte_mid, res.byte_lo} = {accum_q, q_head.sextet};
			fill_d  = '0;
			accum_d = '0;
		end else begin
			accum_d = {accum_q[ACCUM_W-SEXTET_W-1:0], q_head.sextet};
			fill_d  = fill_q + 2'd1;
			if (q_head.is_final) begin
				emit       = 1'b1;
				res.status = ST_PARTIAL;
				fill_d     = '0;
				accum_d    = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			accum_q     <= '0;
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				fill_q  <= fill_d;
				accum_q <= accum_d;
				err_q   <= err_d;
			end
			if (q_pop && emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && emit) begin
			out_q <= res;
		end
	end

endmodule

>>> rtl/core/base64_group_decoder.sv
// Channel  Direction  Signals                       Item
// input    in         in_valid/in_ready, in_item    one character, last flag
// output   out        out_valid/out_ready, out_item three bytes, status, end flag
//
// One character per clock is sustained while out_ready stays high. A result is registered:
// the character is written into the queue, waits there until the back end pops it, and
// then loads the output register; classification is combinational before the queue.
// The queue absorbs output stalls; in_ready drops only when it fills.
// Reset clears the group, error and queue state; no clearing pass is needed.
// Depends on b64gd_pkg, b64gd_front, b64gd_queue and b64gd_back.
module base64_group_decoder import b64gd_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	logic      q_full;
	logic      q_empty;
	logic      q_push;
	logic      q_pop;
	cls_item_t q_in;
	cls_item_t q_head;

	b64gd_front u_front (
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_item   (q_in)
	);

	b64gd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.head      (q_head)
	);

	b64gd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

>>> rtl/core/b64gd_checker.sv
// Port-level checks for the base64 group decoder, bound to the top level.
// Depends on b64gd_pkg and base64_group_decoder.
module b64gd_checker import b64gd_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_item
);

	// A waiting result holds until it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("output item changed while stalled");

	// Error and partial results carry zero bytes.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status != ST_OK |->
			out_item.byte_hi == 8'd0 && out_item.byte_mid == 8'd0 &&
			out_item.byte_lo == 8'd0)
		else $error("non-zero bytes on a failed group");

	// A partial group is only reported at the end of a buffer.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status == ST_PARTIAL |-> out_item.ends_buffer)
		else $error("partial group reported before the buffer end");

endmodule

bind base64_group_decoder b64gd_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_item  (out_item)
);
